>>> rtl/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
package tmcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_BLANK   = 8'h20;
  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [3:0]  RESET_FG   = 4'h7;
  localparam logic [3:0]  RESET_BG   = 4'h0;

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_FG = 2'd0;
  localparam logic [IDX_W-1:0] REG_BG = 2'd1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SW_INIT   = 2'd0,
    SW_CLEAR  = 2'd1,
    SW_COPY   = 2'd2,
    SW_BOTTOM = 2'd3
  } sweep_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_COPY,
    ST_BOTTOM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic   load;
    logic   put;
    logic   set;
    logic   home;
    logic   rd_issue;
    logic   sweep_start;
    logic   sweep;
    sweep_t mode;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic need_scroll;
    logic fill_last;
    logic copy_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/tmcw_ctrl.sv
// Controller state machine of the console writer.
module tmcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tmcw_pkg::status_t stat,
  output tmcw_pkg::cmd_t   cmd
);
  import tmcw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        cmd.mode  = SW_INIT;
        if (stat.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.op)
          OP_PUT: begin
            cmd.put = 1'b1;
            if (stat.need_scroll) begin
              cmd.sweep_start = 1'b1;
              cmd.mode        = SW_COPY;
              state_next      = ST_COPY;
            end else begin
              state_next = ST_RESULT;
            end
          end
          OP_SET: begin
            cmd.set    = 1'b1;
            state_next = ST_RESULT;
          end
          OP_CLEAR: begin
            cmd.home        = 1'b1;
            cmd.sweep_start = 1'b1;
            cmd.mode        = SW_CLEAR;
            state_next      = ST_CLEAR;
          end
          default: begin
            cmd.rd_issue = 1'b1;
            state_next   = ST_RESULT;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        cmd.mode  = SW_CLEAR;
        if (stat.fill_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_COPY: begin
        if (stat.copy_last) begin
          cmd.sweep_start = 1'b1;
          cmd.mode        = SW_BOTTOM;
          state_next      = ST_BOTTOM;
        end else begin
          cmd.sweep = 1'b1;
          cmd.mode  = SW_COPY;
        end
      end
      ST_BOTTOM: begin
        cmd.sweep = 1'b1;
        cmd.mode  = SW_BOTTOM;
        if (stat.fill_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        in_ready = stat.out_free;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/tmcw_datapath.sv
// Datapath: cell store, cursor, sweep pointer, colors and result register.
module tmcw_datapath #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [23:0]                s_tdata,
  input  logic [1:0]                 s_tuser,
  input  logic                       cfg_valid,
  input  logic [tmcw_pkg::IDX_W-1:0] cfg_index,
  input  logic [3:0]                 cfg_data,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [39:0]                m_tdata,
  input  tmcw_pkg::cmd_t             cmd,
  output tmcw_pkg::status_t          stat
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam logic [CW:0]   COL_LIMIT = (CW+1)'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic [3:0]    fg, bg;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  op_t           item_op;
  logic [7:0]    item_ch;
  logic [CW-1:0] item_col;
  logic [RW-1:0] item_row;
  logic [PW-1:0] ptr;
  logic          copy_pend;
  logic [AW-1:0] copy_dst;

  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [CW:0]   col_inc, col_tab;
  logic          printable, wrap, at_last_row;
  logic [CW-1:0] col_put;
  logic [RW-1:0] row_put;
  logic [AW-1:0] cur_addr, item_addr;
  logic [15:0]   blank;

  assign in_col = ({1'b0, s_tdata[15:8]} >= 9'(COLUMNS)) ? COL_LAST : CW'(s_tdata[15:8]);
  assign in_row = ({1'b0, s_tdata[23:16]} >= 9'(ROWS)) ? ROW_LAST : RW'(s_tdata[23:16]);

  assign printable = (item_ch != CH_NEWLINE) && (item_ch != CH_RETURN) && (item_ch != CH_TAB);
  assign col_inc   = (CW+1)'(cur_col) + (CW+1)'(1);
  assign col_tab   = ((CW+1)'(cur_col) + (CW+1)'(8)) & ~(CW+1)'(7);
  assign at_last_row = (cur_row == ROW_LAST);

  always_comb begin
    wrap    = 1'b0;
    col_put = '0;
    if (item_ch == CH_NEWLINE) begin
      wrap = 1'b1;
    end else if (item_ch == CH_RETURN) begin
      wrap = 1'b0;
    end else if (item_ch == CH_TAB) begin
      wrap    = (col_tab >= COL_LIMIT);
      col_put = wrap ? '0 : col_tab[CW-1:0];
    end else begin
      wrap    = (col_inc >= COL_LIMIT);
      col_put = wrap ? '0 : col_inc[CW-1:0];
    end
    row_put = (wrap && !at_last_row) ? cur_row + RW'(1) : cur_row;
  end

  assign cur_addr  = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign item_addr = AW'(item_row) * COLS_A + AW'(item_col);
  assign blank     = {bg, fg, CH_BLANK};

  assign stat.op          = item_op;
  assign stat.need_scroll = wrap && at_last_row;
  assign stat.fill_last   = (ptr == PW'(CELLS - 1));
  assign stat.copy_last   = (ptr == PW'(CELLS));
  assign stat.out_free    = !m_tvalid || m_tready;

  // store ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = item_addr;
    if (cmd.sweep && cmd.mode == SW_COPY && ptr < PW'(CELLS)) begin
      rd_en   = 1'b1;
      rd_addr = ptr[AW-1:0];
    end else if (cmd.rd_issue) begin
      rd_en = 1'b1;
    end
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {bg, fg, item_ch};
    if (copy_pend) begin
      wr_en   = 1'b1;
      wr_addr = copy_dst;
      wr_data = rd_data;
    end else if (cmd.sweep && cmd.mode != SW_COPY) begin
      wr_en   = 1'b1;
      wr_addr = ptr[AW-1:0];
      wr_data = (cmd.mode == SW_INIT) ? RESET_CELL : blank;
    end else if (cmd.put && printable) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg        <= RESET_FG;
      bg        <= RESET_BG;
      cur_col   <= '0;
      cur_row   <= '0;
      ptr       <= '0;
      copy_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_FG) begin
        fg <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_BG) begin
        bg <= cfg_data;
      end
      if (cmd.put) begin
        cur_col <= col_put;
        cur_row <= row_put;
      end else if (cmd.set) begin
        cur_col <= item_col;
        cur_row <= item_row;
      end else if (cmd.home) begin
        cur_col <= '0;
        cur_row <= '0;
      end
      if (cmd.sweep_start) begin
        case (cmd.mode)
          SW_COPY:   ptr <= PW'(COLUMNS);
          SW_BOTTOM: ptr <= PW'(CELLS - COLUMNS);
          default:   ptr <= '0;
        endcase
      end else if (cmd.sweep) begin
        ptr <= ptr + PW'(1);
      end
      copy_pend <= cmd.sweep && cmd.mode == SW_COPY && ptr < PW'(CELLS);
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_dst <= ptr[AW-1:0] - COLS_A;
    if (cmd.load) begin
      item_op  <= op_t'(s_tuser);
      item_ch  <= s_tdata[7:0];
      item_col <= in_col;
      item_row <= in_row;
    end
    if (cmd.out_load) begin
      m_tdata[15:0]  <= (item_op == OP_READ) ? rd_data : 16'h0000;
      m_tdata[22:16] <= 7'(cur_col);
      m_tdata[27:23] <= 5'(cur_row);
      m_tdata[38:28] <= 11'(cur_addr);
      m_tdata[39]    <= 1'b0;
    end
  end

endmodule

>>> rtl/text_mode_console_writer.sv
// Text-mode console writer: cell store with cursor, scroll, clear and cell read.
// Scroll copies the store up one row, one cell per cycle through the store's read port,
// then fills the bottom row with blanks; clear fills the whole store with blanks.
// Without scroll or clear, a new item is accepted while the previous result is loaded,
// when the output is free. Reset: a fill pass blanks the store; s_tready stays low meanwhile.
module text_mode_console_writer #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [23:0]                s_tdata,   // char_code, column, row
  input  logic [1:0]                 s_tuser,   // operation
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [39:0]                m_tdata,   // cell_word, cursor_column, cursor_row,
                                                // cursor_position
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tmcw_pkg::IDX_W-1:0] cfg_index,
  input  logic [3:0]                 cfg_data
);
  import tmcw_pkg::*;

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready = 1'b1;

  tmcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tmcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
